@@ hdl/fdsort_pkg.sv @@
package fdsort_pkg;

  localparam int DEPTH_BITS    = 19;
  localparam int FACE_IDX_BITS = 3;
  localparam int ADDR_BITS     = 4;
  localparam int DATA_BITS     = 32;

  localparam logic [1:0] REG_CAMERA_X = 2'd0;
  localparam logic [1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [1:0] REG_CAMERA_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_INSERT,
    ST_FLUSH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DP_IDLE,
    DP_MUL,
    DP_SUM,
    DP_ROOT
  } dist_phase_t;

  typedef struct packed {
    logic insert;
    logic load;
  } sort_cmd_t;

endpackage

@@ hdl/fdsort_dist.sv @@
module fdsort_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic signed [COORD_BITS-1:0] vertex_z,
  input  logic signed [COORD_BITS-1:0] camera_x,
  input  logic signed [COORD_BITS-1:0] camera_y,
  input  logic signed [COORD_BITS-1:0] camera_z,
  output logic                         done,
  output logic [COORD_BITS:0]          distance
);

  localparam int D        = COORD_BITS + 1;
  localparam int RW       = 2 * D;
  localparam int CNT_BITS = $clog2(D);

  fdsort_pkg::dist_phase_t phase, phase_next;
  logic [CNT_BITS-1:0] cnt;
  logic                cnt_last;
  logic                finish;

  logic signed [D-1:0] diff [3];
  logic [D-1:0]        mag [3];
  logic [D-1:0]        mplier [3];
  logic [RW-1:0]       mcand [3];
  logic [RW-1:0]       prod [3];

  logic [RW-1:0]       rad;
  logic [D+2:0]        rem, rem_sh, trial, rem_next;
  logic [D-1:0]        root, root_next;
  logic                ge;

  always_comb begin
    diff[0] = D'(vertex_x) - D'(camera_x);
    diff[1] = D'(vertex_y) - D'(camera_y);
    diff[2] = D'(vertex_z) - D'(camera_z);
    for (int k = 0; k < 3; k++) begin
      mag[k] = diff[k][D-1] ? D'(-diff[k]) : D'(diff[k]);
    end
  end

  assign cnt_last = (cnt == CNT_BITS'(D - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fdsort_pkg::DP_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    finish     = 1'b0;
    case (phase)
      fdsort_pkg::DP_IDLE: begin
        if (start) begin
          phase_next = fdsort_pkg::DP_MUL;
        end
      end
      fdsort_pkg::DP_MUL: begin
        if (cnt_last) begin
          phase_next = fdsort_pkg::DP_SUM;
        end
      end
      fdsort_pkg::DP_SUM: begin
        phase_next = fdsort_pkg::DP_ROOT;
      end
      fdsort_pkg::DP_ROOT: begin
        if (cnt_last) begin
          phase_next = fdsort_pkg::DP_IDLE;
          finish     = 1'b1;
        end
      end
      default: begin
        phase_next = fdsort_pkg::DP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= finish;
      if (phase == fdsort_pkg::DP_IDLE || phase == fdsort_pkg::DP_SUM) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    rem_sh    = {rem[D:0], rad[RW-1 -: 2]};
    trial     = {1'b0, root, 2'b01};
    ge        = (rem_sh >= trial);
    rem_next  = ge ? (rem_sh - trial) : rem_sh;
    root_next = {root[D-2:0], ge};
  end

  always_ff @(posedge clk) begin
    case (phase)
      fdsort_pkg::DP_IDLE: begin
        if (start) begin
          for (int k = 0; k < 3; k++) begin
            mplier[k] <= mag[k];
            mcand[k]  <= RW'(mag[k]);
            prod[k]   <= '0;
          end
        end
      end
      fdsort_pkg::DP_MUL: begin
        for (int k = 0; k < 3; k++) begin
          if (mplier[k][0]) begin
            prod[k] <= prod[k] + mcand[k];
          end
          mcand[k]  <= {mcand[k][RW-2:0], 1'b0};
          mplier[k] <= {1'b0, mplier[k][D-1:1]};
        end
      end
      fdsort_pkg::DP_SUM: begin
        rad  <= prod[0] + prod[1] + prod[2];
        rem  <= '0;
        root <= '0;
      end
      fdsort_pkg::DP_ROOT: begin
        rad  <= {rad[RW-3:0], 2'b00};
        rem  <= rem_next;
        root <= root_next;
      end
      default: begin
      end
    endcase
  end

  assign distance = root;

endmodule

@@ hdl/fdsort_sorter.sv @@
module fdsort_sorter #(
  parameter int FACE_COUNT = 6
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  fdsort_pkg::sort_cmd_t                   cmd,
  input  logic [fdsort_pkg::DEPTH_BITS-1:0]       key_depth,
  input  logic [$clog2(FACE_COUNT)-1:0]           key_id,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [fdsort_pkg::FACE_IDX_BITS-1:0]    face_index,
  output logic [fdsort_pkg::DEPTH_BITS-1:0]       face_depth,
  output logic                                    last_face
);

  localparam int DB       = fdsort_pkg::DEPTH_BITS;
  localparam int IB       = $clog2(FACE_COUNT);
  localparam int CNT_BITS = $clog2(FACE_COUNT + 1);

  logic [DB-1:0]         dep [FACE_COUNT];
  logic [IB-1:0]         id [FACE_COUNT];
  logic [FACE_COUNT-1:0] vld;
  logic [FACE_COUNT-1:0] keep;

  logic [DB-1:0]         out_dep [FACE_COUNT];
  logic [IB-1:0]         out_id [FACE_COUNT];
  logic [CNT_BITS-1:0]   out_cnt;
  logic                  out_xfer;

  // An entry stays in place when it is at least as deep as the new one, so
  // equal depths keep their load order.
  always_comb begin
    for (int i = 0; i < FACE_COUNT; i++) begin
      keep[i] = vld[i] && (dep[i] >= key_depth);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.load) begin
      vld <= '0;
    end else if (cmd.insert) begin
      if (!keep[0]) begin
        vld[0] <= 1'b1;
      end
      for (int i = 1; i < FACE_COUNT; i++) begin
        if (!keep[i]) begin
          vld[i] <= keep[i-1] ? 1'b1 : vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!keep[0]) begin
        dep[0] <= key_depth;
        id[0]  <= key_id;
      end
      for (int i = 1; i < FACE_COUNT; i++) begin
        if (!keep[i]) begin
          dep[i] <= keep[i-1] ? key_depth : dep[i-1];
          id[i]  <= keep[i-1] ? key_id : id[i-1];
        end
      end
    end
  end

  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < FACE_COUNT; i++) begin
        out_dep[i] <= dep[i];
        out_id[i]  <= id[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < FACE_COUNT - 1; i++) begin
        out_dep[i] <= out_dep[i+1];
        out_id[i]  <= out_id[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else if (cmd.load) begin
      out_cnt <= CNT_BITS'(FACE_COUNT);
    end else if (out_xfer) begin
      out_cnt <= out_cnt - 1'b1;
    end
  end

  assign out_valid  = (out_cnt != '0);
  assign face_index = fdsort_pkg::FACE_IDX_BITS'(out_id[0]);
  assign face_depth = out_dep[0];
  assign last_face  = (out_cnt == CNT_BITS'(1));

  a_load_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (out_cnt == '0))
    else $error("Result line loaded while results are still pending.");

  a_insert_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !vld[FACE_COUNT-1])
    else $error("Face inserted into a full list.");

  a_far_to_near: assert property (@(posedge clk) disable iff (rst)
    (out_cnt > CNT_BITS'(1)) |-> (out_dep[0] >= out_dep[1]))
    else $error("Results are not ordered far to near.");

endmodule

@@ hdl/face_depth_sort_top.sv @@
// Channel   Direction  Handshake           Payload
// config    in         psel/penable/pready camera_x/y/z by paddr, pwdata, prdata
// vertex    in         in_valid/in_stall   vertex_x, vertex_y, vertex_z
// face      out        out_valid/out_stall face_index, face_depth, last_face
//
// For each vertex the block does bit-serial squaring of the three differences,
// then a square root one bit per cycle.
// After the last corner of a face an insert state puts the face into the sorted list.
// After the last face the sorted list moves to the result line in a flush state.
// Reset clears the camera registers, the counters and the list.
// The next run proceeds while results drain; its end waits until the line is empty.
module face_depth_sort_top #(
  parameter int FACE_COUNT       = 6,
  parameter int CORNERS_PER_FACE = 4,
  parameter int COORD_BITS       = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fdsort_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [fdsort_pkg::DATA_BITS-1:0]      pwdata,
  output logic [fdsort_pkg::DATA_BITS-1:0]      prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          vertex_x,
  input  logic signed [COORD_BITS-1:0]          vertex_y,
  input  logic signed [COORD_BITS-1:0]          vertex_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [fdsort_pkg::FACE_IDX_BITS-1:0]  face_index,
  output logic [fdsort_pkg::DEPTH_BITS-1:0]     face_depth,
  output logic                                  last_face
);

  localparam int DB          = fdsort_pkg::DEPTH_BITS;
  localparam int IB          = $clog2(FACE_COUNT);
  localparam int CORNER_BITS = $clog2(CORNERS_PER_FACE);
  localparam int SUM_BITS    = ((COORD_BITS + 1 > DB) ? COORD_BITS + 1 : DB) + 1;
  localparam logic [DB-1:0] DEPTH_MAX = '1;

  logic signed [COORD_BITS-1:0] camera_x, camera_y, camera_z;

  fdsort_pkg::ctrl_state_t state, state_next;
  fdsort_pkg::sort_cmd_t   cmd;

  logic                   dist_start;
  logic                   dist_done;
  logic [COORD_BITS:0]    vert_dist;
  logic [CORNER_BITS-1:0] corner_cnt;
  logic [IB-1:0]          face_cnt;
  logic                   corner_last;
  logic                   face_last;
  logic [DB-1:0]          face_acc;
  logic [SUM_BITS-1:0]    acc_sum;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (cfg_write) begin
      case (paddr[fdsort_pkg::ADDR_BITS-1:2])
        fdsort_pkg::REG_CAMERA_X: camera_x <= pwdata[COORD_BITS-1:0];
        fdsort_pkg::REG_CAMERA_Y: camera_y <= pwdata[COORD_BITS-1:0];
        fdsort_pkg::REG_CAMERA_Z: camera_z <= pwdata[COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[fdsort_pkg::ADDR_BITS-1:2])
      fdsort_pkg::REG_CAMERA_X: prdata = fdsort_pkg::DATA_BITS'(camera_x);
      fdsort_pkg::REG_CAMERA_Y: prdata = fdsort_pkg::DATA_BITS'(camera_y);
      fdsort_pkg::REG_CAMERA_Z: prdata = fdsort_pkg::DATA_BITS'(camera_z);
      default:                  prdata = '0;
    endcase
  end

  fdsort_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .start    (dist_start),
    .vertex_x (vertex_x),
    .vertex_y (vertex_y),
    .vertex_z (vertex_z),
    .camera_x (camera_x),
    .camera_y (camera_y),
    .camera_z (camera_z),
    .done     (dist_done),
    .distance (vert_dist)
  );

  assign corner_last = (corner_cnt == CORNER_BITS'(CORNERS_PER_FACE - 1));
  assign face_last   = (face_cnt == IB'(FACE_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdsort_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    dist_start = 1'b0;
    case (state)
      fdsort_pkg::ST_IDLE: begin
        if (in_valid) begin
          dist_start = 1'b1;
          state_next = fdsort_pkg::ST_WORK;
        end
      end
      fdsort_pkg::ST_WORK: begin
        if (dist_done) begin
          state_next = corner_last ? fdsort_pkg::ST_INSERT : fdsort_pkg::ST_IDLE;
        end
      end
      fdsort_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = face_last ? fdsort_pkg::ST_FLUSH : fdsort_pkg::ST_IDLE;
      end
      fdsort_pkg::ST_FLUSH: begin
        if (!out_valid) begin
          cmd.load   = 1'b1;
          state_next = fdsort_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fdsort_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != fdsort_pkg::ST_IDLE);

  always_comb begin
    acc_sum = ((corner_cnt == '0) ? SUM_BITS'(0) : SUM_BITS'(face_acc)) + SUM_BITS'(vert_dist);
  end

  always_ff @(posedge clk) begin
    if (state == fdsort_pkg::ST_WORK && dist_done) begin
      face_acc <= (acc_sum > SUM_BITS'(DEPTH_MAX)) ? DEPTH_MAX : acc_sum[DB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_cnt <= '0;
      face_cnt   <= '0;
    end else begin
      if (state == fdsort_pkg::ST_WORK && dist_done) begin
        corner_cnt <= corner_last ? '0 : corner_cnt + 1'b1;
      end
      if (cmd.insert) begin
        face_cnt <= face_last ? '0 : face_cnt + 1'b1;
      end
    end
  end

  fdsort_sorter #(
    .FACE_COUNT(FACE_COUNT)
  ) u_sorter (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .key_depth  (face_acc),
    .key_id     (face_cnt),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .face_index (face_index),
    .face_depth (face_depth),
    .last_face  (last_face)
  );

endmodule
